// ===== rtl/tcq_pkg.sv =====
// Shared types and constants for the two-class ticket queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package tcq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TICKET_BITS_DEF = 16;
	localparam int FUNC_BITS       = 2;
	localparam int CTR_BITS        = 8;

	typedef enum logic [FUNC_BITS-1:0] {
		FUNC_ADD_NORMAL = 2'd0,
		FUNC_ADD_PRIO   = 2'd1,
		FUNC_REMOVE     = 2'd2,
		FUNC_NOP        = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/two_class_ticket_queue.sv =====
// Top level of the two-class ticket queue: control plus entry store.
// Depends on tcq_pkg, tcq_ctrl, tcq_store.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------
//   in      | in_valid / in_stall | func, counter_id
//   out     | out_valid/out_stall | accepted, ticket_given, removed_counter,
//           |                     | removed_ticket, removed_priority,
//           |                     | now_empty, occupancy
//
// Each command is accepted in the idle state, which updates the ring pointers
// and issues the store write (add) or head read (remove); the execute state
// then takes the registered read data and loads the result register.
// Reset clears state, pointers, counts and out_valid; the store is never cleared.
// A new command is taken while a result waits; its own result then waits in
// the execute state until the result register frees up.
`default_nettype none

module two_class_ticket_queue import tcq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TICKET_BITS = TICKET_BITS_DEF,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [FUNC_BITS-1:0]   func,
	input  wire logic [CTR_BITS-1:0]    counter_id,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        accepted,
	output logic      [TICKET_BITS-1:0] ticket_given,
	output logic      [CTR_BITS-1:0]    removed_counter,
	output logic      [TICKET_BITS-1:0] removed_ticket,
	output logic                        removed_priority,
	output logic                        now_empty,
	output logic      [CW-1:0]          occupancy
);

	localparam int AW = $clog2(QUEUE_DEPTH) + 1;
	localparam int DW = TICKET_BITS + CTR_BITS;

	mem_ctl_t      mem_ctl;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [DW-1:0] mem_wdata, mem_rdata;

	tcq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TICKET_BITS(TICKET_BITS)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.counter_id       (counter_id),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.accepted         (accepted),
		.ticket_given     (ticket_given),
		.removed_counter  (removed_counter),
		.removed_ticket   (removed_ticket),
		.removed_priority (removed_priority),
		.now_empty        (now_empty),
		.occupancy        (occupancy),
		.mem_ctl          (mem_ctl),
		.mem_waddr        (mem_waddr),
		.mem_wdata        (mem_wdata),
		.mem_raddr        (mem_raddr),
		.mem_rdata        (mem_rdata)
	);

	tcq_store #(
		.AW(AW),
		.DW(DW)
	) u_store (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

// ===== rtl/tcq_store.sv =====
// Entry store: one synchronous memory, one write and one read port,
// registered read data. Depends on tcq_pkg.
`default_nettype none

module tcq_store import tcq_pkg::*; #(
	parameter int AW = $clog2(QUEUE_DEPTH_DEF) + 1,
	parameter int DW = TICKET_BITS_DEF + CTR_BITS
) (
	input  wire logic          clk,
	input  wire mem_ctl_t      ctl,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/tcq_ctrl.sv =====
// Command control: per-class ring pointers and counts, ticket generation,
// sequencer and result register. Depends on tcq_pkg; drives tcq_store.
`default_nettype none

module tcq_ctrl import tcq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TICKET_BITS = TICKET_BITS_DEF,
	localparam int PW = $clog2(QUEUE_DEPTH),
	localparam int CW = $clog2(QUEUE_DEPTH + 1),
	localparam int AW = PW + 1,
	localparam int DW = TICKET_BITS + CTR_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [FUNC_BITS-1:0]   func,
	input  wire logic [CTR_BITS-1:0]    counter_id,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        accepted,
	output logic      [TICKET_BITS-1:0] ticket_given,
	output logic      [CTR_BITS-1:0]    removed_counter,
	output logic      [TICKET_BITS-1:0] removed_ticket,
	output logic                        removed_priority,
	output logic                        now_empty,
	output logic      [CW-1:0]          occupancy,
	output mem_ctl_t                    mem_ctl,
	output logic      [AW-1:0]          mem_waddr,
	output logic      [DW-1:0]          mem_wdata,
	output logic      [AW-1:0]          mem_raddr,
	input  wire logic [DW-1:0]          mem_rdata
);

	localparam logic [PW-1:0]          PTR_LAST   = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0]          CNT_FULL   = CW'(QUEUE_DEPTH);
	localparam logic [TICKET_BITS-1:0] TICK_MAX   = '1;
	localparam logic [TICKET_BITS-1:0] TICK_FIRST = TICKET_BITS'(1);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	state_t state_q;

	// priority entries live in the upper half of the store, normal in the lower
	logic [PW-1:0] head_p_q, tail_p_q, head_n_q, tail_n_q;
	logic [CW-1:0] cnt_p_q, cnt_n_q;
	logic [TICKET_BITS-1:0] last_p_q, last_n_q;

	logic                   acc_s1, add_s1, rem_s1, rprio_s1;
	logic [TICKET_BITS-1:0] tick_s1;
	logic [CW-1:0]          occ_s1;

	logic                   out_valid_q, accepted_q, removed_priority_q, now_empty_q;
	logic [TICKET_BITS-1:0] ticket_given_q, removed_ticket_q;
	logic [CTR_BITS-1:0]    removed_counter_q;
	logic [CW-1:0]          occupancy_q;

	func_t                  cmd;
	logic                   fire, is_add, is_rem, add_prio, rem_prio, add_ok, rem_ok;
	logic                   out_load;
	logic [CW-1:0]          total, occ_nxt;
	logic [TICKET_BITS-1:0] latest, new_tick;

	assign cmd      = func_t'(func);
	assign fire     = in_valid && (state_q == ST_IDLE);
	assign total    = cnt_p_q + cnt_n_q;
	assign rem_prio = (cnt_p_q != '0);

	always_comb begin
		is_add   = 1'b0;
		is_rem   = 1'b0;
		add_prio = 1'b0;
		unique case (cmd)
			FUNC_ADD_NORMAL: is_add = 1'b1;
			FUNC_ADD_PRIO: begin
				is_add   = 1'b1;
				add_prio = 1'b1;
			end
			FUNC_REMOVE: is_rem = 1'b1;
			FUNC_NOP: ;
			default: ;
		endcase
	end

	assign add_ok = is_add && (total != CNT_FULL);
	assign rem_ok = is_rem && (total != '0);

	// tickets rise with insertion order, so each ring's tail holds its largest
	always_comb begin
		if (cnt_p_q != '0 && cnt_n_q != '0) begin
			latest = (last_p_q > last_n_q) ? last_p_q : last_n_q;
		end else if (cnt_p_q != '0) begin
			latest = last_p_q;
		end else begin
			latest = last_n_q;
		end
		if (total == '0) begin
			new_tick = TICK_FIRST;
		end else if (latest == TICK_MAX) begin
			new_tick = TICK_MAX;
		end else begin
			new_tick = latest + TICKET_BITS'(1);
		end
	end

	always_comb begin
		priority if (add_ok) begin
			occ_nxt = total + CW'(1);
		end else if (rem_ok) begin
			occ_nxt = total - CW'(1);
		end else begin
			occ_nxt = total;
		end
	end

	assign mem_ctl.wr_en = fire && add_ok;
	assign mem_ctl.rd_en = fire && rem_ok;
	assign mem_waddr     = add_prio ? {1'b1, tail_p_q} : {1'b0, tail_n_q};
	assign mem_raddr     = rem_prio ? {1'b1, head_p_q} : {1'b0, head_n_q};
	assign mem_wdata     = {new_tick, counter_id};

	assign out_load = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_p_q    <= '0;
			tail_p_q    <= '0;
			head_n_q    <= '0;
			tail_n_q    <= '0;
			cnt_p_q     <= '0;
			cnt_n_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_EXEC;
				ST_EXEC: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase

			if (fire && add_ok) begin
				if (add_prio) begin
					tail_p_q <= ptr_inc(tail_p_q);
					cnt_p_q  <= cnt_p_q + CW'(1);
				end else begin
					tail_n_q <= ptr_inc(tail_n_q);
					cnt_n_q  <= cnt_n_q + CW'(1);
				end
			end
			if (fire && rem_ok) begin
				if (rem_prio) begin
					head_p_q <= ptr_inc(head_p_q);
					cnt_p_q  <= cnt_p_q - CW'(1);
				end else begin
					head_n_q <= ptr_inc(head_n_q);
					cnt_n_q  <= cnt_n_q - CW'(1);
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (add_ok && add_prio) last_p_q <= new_tick;
			if (add_ok && !add_prio) last_n_q <= new_tick;
			acc_s1   <= add_ok || rem_ok;
			add_s1   <= add_ok;
			rem_s1   <= rem_ok;
			rprio_s1 <= rem_prio;
			tick_s1  <= new_tick;
			occ_s1   <= occ_nxt;
		end
		// store read data is held until the next read, so a stalled result waits safely
		if (out_load) begin
			accepted_q         <= acc_s1;
			ticket_given_q     <= add_s1 ? tick_s1 : '0;
			removed_counter_q  <= rem_s1 ? mem_rdata[CTR_BITS-1:0] : '0;
			removed_ticket_q   <= rem_s1 ? mem_rdata[DW-1:CTR_BITS] : '0;
			removed_priority_q <= rem_s1 && rprio_s1;
			now_empty_q        <= (occ_s1 == '0);
			occupancy_q        <= occ_s1;
		end
	end

	assign out_valid        = out_valid_q;
	assign accepted         = accepted_q;
	assign ticket_given     = ticket_given_q;
	assign removed_counter  = removed_counter_q;
	assign removed_ticket   = removed_ticket_q;
	assign removed_priority = removed_priority_q;
	assign now_empty        = now_empty_q;
	assign occupancy        = occupancy_q;

endmodule

`default_nettype wire

// ===== rtl/tcq_checker.sv =====
// Port-level checks on the result channel of the ticket queue, and the bind
// that attaches them to two_class_ticket_queue. Depends on tcq_pkg.
`default_nettype none

module tcq_checker import tcq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TICKET_BITS = TICKET_BITS_DEF,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic                   accepted,
	input wire logic [TICKET_BITS-1:0] ticket_given,
	input wire logic [CTR_BITS-1:0]    removed_counter,
	input wire logic [TICKET_BITS-1:0] removed_ticket,
	input wire logic                   removed_priority,
	input wire logic                   now_empty,
	input wire logic [CW-1:0]          occupancy
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ticket_given)
			&& $stable(removed_ticket) && $stable(occupancy))
		else $error("result beat changed while stalled");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= CW'(QUEUE_DEPTH))
		else $error("occupancy above queue depth");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> now_empty == (occupancy == '0))
		else $error("empty flag disagrees with occupancy");

	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> ticket_given == '0 && removed_ticket == '0
			&& removed_counter == '0 && !removed_priority)
		else $error("refused command reports data");

	// tickets are never zero, so an add and a remove are told apart by them
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> (ticket_given != '0) != (removed_ticket != '0))
		else $error("accepted beat is neither a pure add nor a pure remove");

endmodule

bind two_class_ticket_queue tcq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH),
	.TICKET_BITS(TICKET_BITS)
) u_tcq_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for two_class_ticket_queue: directed and random commands.
// Depends on tcq_pkg and the RTL; a mirror of the ticket line predicts every result beat.

module testbench;
	import tcq_pkg::*;

	localparam int QDEPTH     = QUEUE_DEPTH_DEF;
	localparam int TBITS      = TICKET_BITS_DEF;
	localparam int OCC_BITS   = $clog2(QDEPTH + 1);
	localparam int TICKET_TOP = (1 << TBITS) - 1;
	localparam int HANG_LIMIT = 4000;
	localparam int RANDOM_CMDS = 1950;

	typedef struct packed {
		logic                acc;
		logic [TBITS-1:0]    tkt_given;
		logic [CTR_BITS-1:0] rm_ctr;
		logic [TBITS-1:0]    rm_tkt;
		logic                rm_prio;
		logic                empty;
		logic [OCC_BITS-1:0] occ;
	} outcome_t;

	// Mirror of the waiting line plus the outcomes still owed by the block.
	class ticket_line_mirror;
		logic [TBITS-1:0]    line_ticket[QDEPTH];
		logic [CTR_BITS-1:0] line_ctr[QDEPTH];
		logic                line_prio[QDEPTH];
		int                  line_count;
		int                  prio_count;
		outcome_t            pending_outcomes[$];
		int                  failures;
		int                  reported;

		function new();
			line_count = 0;
			prio_count = 0;
			failures   = 0;
			reported   = 0;
		endfunction

		function logic [TBITS-1:0] next_ticket();
			logic [TBITS-1:0] best;
			best = '0;
			if (line_count == 0)
				return 1;
			for (int i = 0; i < line_count; i++)
				if (line_ticket[i] > best)
					best = line_ticket[i];
			return (best == TICKET_TOP[TBITS-1:0]) ? best : best + 1'b1;
		endfunction

		function void insert_entry(int pos, logic [TBITS-1:0] t, logic [CTR_BITS-1:0] c,
				logic p);
			for (int i = line_count; i > pos; i--) begin
				line_ticket[i] = line_ticket[i-1];
				line_ctr[i]    = line_ctr[i-1];
				line_prio[i]   = line_prio[i-1];
			end
			line_ticket[pos] = t;
			line_ctr[pos]    = c;
			line_prio[pos]   = p;
			line_count++;
		endfunction

		function outcome_t apply_command(func_t f, logic [CTR_BITS-1:0] c);
			outcome_t         o;
			logic [TBITS-1:0] t;
			int               pos;
			o = '0;
			case (f)
				FUNC_ADD_NORMAL, FUNC_ADD_PRIO: begin
					if (line_count < QDEPTH) begin
						t = next_ticket();
						if (f == FUNC_ADD_NORMAL) begin
							insert_entry(line_count, t, c, 1'b0);
						end else begin
							// priority entries stay packed at the head
							pos = (prio_count > line_count) ? line_count : prio_count;
							insert_entry(pos, t, c, 1'b1);
							prio_count = pos + 1;
						end
						o.acc       = 1'b1;
						o.tkt_given = t;
					end
				end
				FUNC_REMOVE: begin
					if (line_count > 0) begin
						o.rm_tkt  = line_ticket[0];
						o.rm_ctr  = line_ctr[0];
						o.rm_prio = line_prio[0];
						for (int i = 1; i < line_count; i++) begin
							line_ticket[i-1] = line_ticket[i];
							line_ctr[i-1]    = line_ctr[i];
							line_prio[i-1]   = line_prio[i];
						end
						line_count--;
						if (o.rm_prio && prio_count > 0)
							prio_count--;
						o.acc = 1'b1;
					end
				end
				default: ;
			endcase
			o.empty = (line_count == 0);
			o.occ   = OCC_BITS'(line_count);
			return o;
		endfunction

		function void note_command(func_t f, logic [CTR_BITS-1:0] c);
			pending_outcomes.push_back(apply_command(f, c));
		endfunction

		function void flag(string what, outcome_t want, outcome_t got);
			failures++;
			if (reported < 10) begin
				reported++;
				$display("mismatch: %s exp acc=%0d tkt=%0d rctr=%0d rtkt=%0d",
					what, want.acc, want.tkt_given, want.rm_ctr, want.rm_tkt);
				$display("          exp rprio=%0d empty=%0d occ=%0d",
					want.rm_prio, want.empty, want.occ);
				$display("          got acc=%0d tkt=%0d rctr=%0d rtkt=%0d",
					got.acc, got.tkt_given, got.rm_ctr, got.rm_tkt);
				$display("          got rprio=%0d empty=%0d occ=%0d",
					got.rm_prio, got.empty, got.occ);
			end
		endfunction

		function void check_outcome(outcome_t got);
			outcome_t want;
			if (pending_outcomes.size() == 0) begin
				flag("unexpected beat", '0, got);
				return;
			end
			want = pending_outcomes.pop_front();
			if (got !== want)
				flag("field differs", want, got);
		endfunction

		function void flush_leftovers();
			while (pending_outcomes.size() != 0)
				flag("missing beat", pending_outcomes.pop_front(), '0);
		endfunction
	endclass

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic [FUNC_BITS-1:0]  func       = '0;
	logic [CTR_BITS-1:0]   counter_id = '0;
	logic                  out_stall  = 1'b0;
	logic                  in_stall;
	logic                  out_valid;
	logic                  accepted;
	logic [TBITS-1:0]      ticket_given;
	logic [CTR_BITS-1:0]   removed_counter;
	logic [TBITS-1:0]      removed_ticket;
	logic                  removed_priority;
	logic                  now_empty;
	logic [OCC_BITS-1:0]   occupancy;

	ticket_line_mirror board = new();
	int burst_left   = 0;
	int stall_pct    = 0;
	int stall_span   = 0;
	int hang_cycles  = 0;

	two_class_ticket_queue u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.counter_id      (counter_id),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.accepted        (accepted),
		.ticket_given    (ticket_given),
		.removed_counter (removed_counter),
		.removed_ticket  (removed_ticket),
		.removed_priority(removed_priority),
		.now_empty       (now_empty),
		.occupancy       (occupancy)
	);

	always #2 clk = ~clk;

	// receiver backpressure: stall density is redrawn whenever its random span runs out
	always @(posedge clk) begin
		if (stall_span == 0) begin
			case ($urandom_range(3))
				0: stall_pct <= 0;
				1: stall_pct <= 10;
				2: stall_pct <= 40;
				default: stall_pct <= 85;
			endcase
			stall_span <= $urandom_range(200, 20);
		end else begin
			stall_span <= stall_span - 1;
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_outcome({accepted, ticket_given, removed_counter, removed_ticket,
					removed_priority, now_empty, occupancy});
			if (in_valid && !in_stall)
				board.note_command(func_t'(func), counter_id);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				hang_cycles <= 0;
			end else if (hang_cycles == HANG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				hang_cycles <= hang_cycles + 1;
			end
		end
	end

	// one command beat; returns at the edge where it is taken
	task automatic send_command(func_t f, logic [CTR_BITS-1:0] c);
		int gap;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(12, 1);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(24, 1);
		end
		in_valid   <= 1'b1;
		func       <= f;
		counter_id <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
	endtask

	function automatic func_t any_add();
		return $urandom_range(1) ? FUNC_ADD_PRIO : FUNC_ADD_NORMAL;
	endfunction

	initial begin
		int add_pct;
		int mode_left;
		int r;
		func_t f;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-line corner cases, then priority insert with no normal entries behind it
		send_command(FUNC_REMOVE, 8'hFF);
		send_command(FUNC_NOP, 8'h5A);
		send_command(FUNC_ADD_PRIO, 8'h00);
		send_command(FUNC_ADD_NORMAL, 8'hFF);
		send_command(FUNC_ADD_PRIO, 8'hA5);
		send_command(FUNC_REMOVE, 8'h00);
		send_command(FUNC_REMOVE, 8'h00);
		send_command(FUNC_REMOVE, 8'h00);
		for (int i = 0; i < QDEPTH; i++)
			send_command(i[0] ? FUNC_ADD_PRIO : FUNC_ADD_NORMAL, 8'(i * 17));
		// full line refuses both classes
		send_command(FUNC_ADD_NORMAL, 8'h3C);
		send_command(FUNC_ADD_PRIO, 8'hC3);

		add_pct   = 50;
		mode_left = 0;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (mode_left == 0) begin
				case ($urandom_range(2))
					0: add_pct = 75;
					1: add_pct = 25;
					default: add_pct = 50;
				endcase
				mode_left = $urandom_range(120, 20);
			end
			mode_left--;
			r = $urandom_range(99);
			if (r < 4)
				f = FUNC_NOP;
			else if ($urandom_range(99) < add_pct)
				f = any_add();
			else
				f = FUNC_REMOVE;
			send_command(f, 8'($urandom_range(255)));
		end
		in_valid <= 1'b0;

		while (board.pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		board.flush_leftovers();
		if (board.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tcq_pkg.sv
rtl/tcq_store.sv
rtl/tcq_ctrl.sv
rtl/two_class_ticket_queue.sv
rtl/tcq_checker.sv
bench/testbench.sv
